// ----- src/assert_macros.svh -----
// Assertion helpers; expect clk and rst in scope at the place of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SUT_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define SUT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/sut_pkg.sv -----
`default_nettype none

package sut_pkg;

  localparam int DATA_W   = 32;  // Q16.16 entry width
  localparam int GAP_W    = 33;  // |a - b| of two 32-bit signed values
  localparam int TOL_W    = 16;
  localparam int OP_W     = 2;
  localparam int IDX_IN_W = 8;
  localparam int ST_W     = 3;
  localparam int POS_W    = 8;
  localparam int TOTAL_W  = 9;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;  // decodes as a read

  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_CLEARED   = 3'd3;
  localparam logic [ST_W-1:0] ST_READ_OK   = 3'd4;
  localparam logic [ST_W-1:0] ST_BEYOND    = 3'd5;

  // What a cell tells its right-hand neighbor.
  typedef struct packed {
    logic             lt;   // entry valid and below the probe value
    logic             ok;   // entry valid and within tolerance
    logic [GAP_W-1:0] gap;  // |probe - entry|
  } link_t;

  // Duplicate match flags raised by a cell.
  typedef struct packed {
    logic self;  // this slot is the match
    logic left;  // the slot to the left is the match
  } hit_t;

  // Write controls into a cell.
  typedef struct packed {
    logic load;   // take the new value
    logic shift;  // take the left neighbor's entry
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/sut_cell.sv -----
`default_nettype none

module sut_cell (
  input  logic                          clk,
  input  logic [sut_pkg::DATA_W-1:0]    probe,
  input  logic [sut_pkg::TOL_W-1:0]     tol,
  input  logic                          cell_valid,
  input  logic                          right_valid,
  input  sut_pkg::link_t                left_link,
  input  logic [sut_pkg::DATA_W-1:0]    left_entry,
  input  sut_pkg::cell_ctl_t            ctl,
  output sut_pkg::link_t                link,
  output sut_pkg::hit_t                 hit,
  output logic [sut_pkg::DATA_W-1:0]    entry
);
  import sut_pkg::*;

  logic [GAP_W-1:0]  probe_x;
  logic [GAP_W-1:0]  entry_x;
  logic              probe_ge;
  logic              is_hi;
  logic              lo_win;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= probe;
    end else if (ctl.shift) begin
      entry <= left_entry;
    end
  end

  assign probe_x  = {probe[DATA_W-1], probe};
  assign entry_x  = {entry[DATA_W-1], entry};
  assign probe_ge = $signed(probe) >= $signed(entry);

  assign link.gap = probe_ge ? (probe_x - entry_x) : (entry_x - probe_x);
  assign link.lt  = cell_valid && probe_ge && (probe != entry);
  assign link.ok  = cell_valid && (link.gap <= GAP_W'(tol));

  // First slot not below the probe: the upper neighbor.
  assign is_hi  = cell_valid && !link.lt && left_link.lt;
  // Lower neighbor wins when it is in range and no farther (ties go low).
  assign lo_win = is_hi && left_link.ok && (!link.ok || (left_link.gap <= link.gap));

  // Last valid slot below the probe, with nothing above it: it is the only neighbor.
  assign hit.self = (is_hi && link.ok && !lo_win) || (link.lt && !right_valid && link.ok);
  assign hit.left = lo_win;

endmodule

`default_nettype wire

// ----- src/sorted_unique_insert_table.sv -----
// Sorted distinct-value table. Holds up to TABLE_DEPTH signed Q16.16 values in ascending
// order, one per cell of a row of cells. Every word on the input channel (insert, clear or
// read) gives exactly one result word. An insert whose value lies within the tolerance
// register of its nearest stored neighbor is reported as a duplicate at that neighbor's
// slot (on equal distance the lower slot wins); otherwise the larger entries move up one
// cell and the value lands in order, or the insert is reported full and dropped. A clear
// only resets the count. Each word is first accepted; then every cell compares its entry
// with the value in parallel and the results are registered; then the neighbor match is
// resolved, the row shifts and the result register is loaded. The next word is accepted
// while the previous result still waits on the output; a result held on the output stalls
// only the final step of the next word. The tolerance register is written on its own
// channel, always ready, and must only change while the table is idle.
`default_nettype none

`include "assert_macros.svh"

module sorted_unique_insert_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  // tolerance register
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sut_pkg::TOL_W-1:0]      cfg_data,
  // input words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sut_pkg::OP_W-1:0]       opcode,
  input  logic signed [sut_pkg::DATA_W-1:0] value,
  input  logic [sut_pkg::IDX_IN_W-1:0]   index,
  // result words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sut_pkg::ST_W-1:0]       status,
  output logic [sut_pkg::POS_W-1:0]      position,
  output logic [sut_pkg::TOTAL_W-1:0]    entry_total,
  output logic signed [sut_pkg::DATA_W-1:0] read_value
);
  import sut_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  // common width for count, index and slot-number arithmetic
  localparam int CMP_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_t;

  state_t state;

  // registers
  logic [CNT_W-1:0]       count;
  logic [TOL_W-1:0]       tol;
  logic [OP_W-1:0]        op_q;
  logic [DATA_W-1:0]      val_q;
  logic [IDX_IN_W-1:0]    idx_q;
  logic [TABLE_DEPTH-1:0] lt_q;    // thermometer: slots below the value
  logic [TABLE_DEPTH-1:0] hit_q;   // one-hot duplicate slot, or none
  logic                   rd_ok_q;
  logic [DATA_W-1:0]      rd_q;

  // cell row
  link_t                  cell_link  [TABLE_DEPTH];
  hit_t                   cell_hit   [TABLE_DEPTH];
  logic [DATA_W-1:0]      cell_entry [TABLE_DEPTH];
  cell_ctl_t              cell_ctl   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_valid;
  logic [TABLE_DEPTH-1:0] lt_vec;
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] ins_pt;

  // resolve stage
  logic [CMP_W-1:0]       idx_ext;
  logic [CMP_W-1:0]       cnt_ext;
  logic [DATA_W-1:0]      rd_sel;
  logic [CMP_W-1:0]       hit_pos;
  logic [CMP_W-1:0]       ins_pos;
  logic                   dup;
  logic                   full;
  logic                   apply_go;
  logic                   ins_do;
  logic [ST_W-1:0]        status_next;
  logic [CMP_W-1:0]       pos_next;
  logic [CNT_W-1:0]       count_next;
  logic [DATA_W-1:0]      rv_next;
  logic [CMP_W-1:0]       total_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    link_t             left_link;
    logic [DATA_W-1:0] left_entry;
    logic              right_valid;

    if (g == 0) begin : g_head
      // an imaginary slot below everything, never a match
      assign left_link       = '{lt: 1'b1, ok: 1'b0, gap: '0};
      assign left_entry      = val_q;
      assign ins_pt[g]       = !lt_q[g];
      assign cell_ctl[g].shift = 1'b0;
    end else begin : g_body
      assign left_link       = cell_link[g-1];
      assign left_entry      = cell_entry[g-1];
      assign ins_pt[g]       = !lt_q[g] && lt_q[g-1];
      assign cell_ctl[g].shift = ins_do && !lt_q[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign hit_vec[g]  = cell_hit[g].self;
    end else begin : g_inner
      assign right_valid = cell_valid[g+1];
      assign hit_vec[g]  = cell_hit[g].self || cell_hit[g+1].left;
    end

    assign cell_valid[g]    = (count > CNT_W'(g));
    assign lt_vec[g]        = cell_link[g].lt;
    assign cell_ctl[g].load = ins_do && ins_pt[g];

    sut_cell u_cell (
      .clk         (clk),
      .probe       (val_q),
      .tol         (tol),
      .cell_valid  (cell_valid[g]),
      .right_valid (right_valid),
      .left_link   (left_link),
      .left_entry  (left_entry),
      .ctl         (cell_ctl[g]),
      .link        (cell_link[g]),
      .hit         (cell_hit[g]),
      .entry       (cell_entry[g])
    );
  end

  assign idx_ext = CMP_W'(idx_q);
  assign cnt_ext = CMP_W'(count);

  // read select: AND-OR over the row
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      rd_sel = rd_sel | (cell_entry[i] & {DATA_W{idx_ext == CMP_W'(i)}});
    end
  end

  // one-hot to slot number
  always_comb begin
    hit_pos = '0;
    ins_pos = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_pos = hit_pos | (CMP_W'(i) & {CMP_W{hit_q[i]}});
      ins_pos = ins_pos | (CMP_W'(i) & {CMP_W{ins_pt[i]}});
    end
  end

  assign dup      = |hit_q;
  assign full     = (count == CNT_W'(TABLE_DEPTH));
  assign apply_go = (state == S_APPLY) && (!out_valid || out_ready);
  assign ins_do   = apply_go && (op_q == OP_INSERT) && !dup && !full;

  always_comb begin
    status_next = ST_CLEARED;
    pos_next    = '0;
    count_next  = count;
    rv_next     = '0;
    case (op_q)
      OP_CLEAR: begin
        status_next = ST_CLEARED;
        count_next  = '0;
      end
      OP_INSERT: begin
        if (dup) begin
          status_next = ST_DUPLICATE;
          pos_next    = hit_pos;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_INSERTED;
          pos_next    = ins_pos;
          count_next  = count + 1'b1;
        end
      end
      default: begin  // read, and the spare code
        pos_next = idx_ext;
        if (rd_ok_q) begin
          status_next = ST_READ_OK;
          rv_next     = rd_q;
        end else begin
          status_next = ST_BEYOND;
        end
      end
    endcase
  end

  assign total_ext = CMP_W'(count_next);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q  <= opcode;
      val_q <= value;
      idx_q <= index;
    end
    if (state == S_EVAL) begin
      lt_q    <= lt_vec;
      hit_q   <= hit_vec;
      rd_ok_q <= (idx_ext < cnt_ext);
      rd_q    <= rd_sel;
    end
    if (apply_go) begin
      status      <= status_next;
      position    <= pos_next[POS_W-1:0];
      entry_total <= total_ext[TOTAL_W-1:0];
      read_value  <= rv_next;
    end

    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      tol       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tol <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (apply_go) begin
            state     <= S_IDLE;
            count     <= count_next;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SUT_ASSERT_IMPL(a_count_range, 1'b1, count <= CNT_W'(TABLE_DEPTH), "entry count past depth")
  `SUT_ASSERT_IMPL(a_hit_onehot, state == S_APPLY, $onehot0(hit_q), "more than one match slot")
  `SUT_ASSERT_NEXT(a_insert_count, ins_do, count == $past(count) + 1'b1, "insert lost count")
  `SUT_ASSERT_NEXT(a_result_load, apply_go, out_valid, "result word not loaded")

endmodule

`default_nettype wire
